// ===== src/dslpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Distance sampled line pattern classifier package
// Shared widths, register indexes, reset values, thresholds and handshake
// structs between the controller and the two window units.
// ----------------------------------------------------------------------------
`default_nettype none

package dslpc_pkg;

  localparam int DIST_W     = 32;
  localparam int COUNT_W    = 8;
  localparam int STEP_W     = 16;
  localparam int THR_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int LINE_WINDOW_DEF   = 12;
  localparam int SENSOR_WINDOW_DEF = 20;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd2;

  localparam logic [STEP_W-1:0] LINE_STEP_RST   = 16'd400;
  localparam logic [STEP_W-1:0] SENSOR_STEP_RST = 16'd50;
  localparam logic [THR_W-1:0]  THRESHOLD_RST   = 8'd10;

  // Pattern thresholds in percent of the line window.
  localparam int PCT_SCALE      = 100;
  localparam int ROUND_ZERO_PCT = 35;
  localparam int ROUND_ONE_PCT  = 35;
  localparam int BARREL_TWO_PCT = 20;
  localparam int BARREL_ONE_PCT = 50;
  localparam int TRIPLE_PCT     = 85;
  localparam int ROUND_MIN_CHANGES  = 4;
  localparam int BARREL_MIN_CHANGES = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SAMPLE,
    ST_SCAN,
    ST_WAIT,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic sample;
    logic scan;
  } scan_cmd_t;

  typedef struct packed {
    logic done;
    logic roundabout;
    logic barrel;
    logic triple;
  } line_res_t;

  typedef struct packed {
    logic done;
    logic finish;
    logic crossing;
  } sensor_res_t;

endpackage

`default_nettype wire

// ===== src/dslpc_line_hist.sv =====
// ----------------------------------------------------------------------------
// Line window histogram unit
// Holds the line count ring in a synchronous memory, writes samples and sweeps
// the ring once per tick to build the histogram and circular change count.
// ----------------------------------------------------------------------------
`default_nettype none

module dslpc_line_hist #(
  parameter int LINE_WINDOW = dslpc_pkg::LINE_WINDOW_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire dslpc_pkg::scan_cmd_t        cmd_i,
  input  wire [dslpc_pkg::COUNT_W-1:0]     data_i,
  output dslpc_pkg::line_res_t             res_o
);

  localparam int AW = $clog2(LINE_WINDOW);
  localparam int CW = $clog2(LINE_WINDOW + 1);
  localparam logic [AW-1:0] LAST = AW'(LINE_WINDOW - 1);

  localparam int ROUND_ZERO_MIN =
    (dslpc_pkg::ROUND_ZERO_PCT * LINE_WINDOW + dslpc_pkg::PCT_SCALE - 1) / dslpc_pkg::PCT_SCALE;
  localparam int ROUND_ONE_MIN =
    (dslpc_pkg::ROUND_ONE_PCT * LINE_WINDOW + dslpc_pkg::PCT_SCALE - 1) / dslpc_pkg::PCT_SCALE;
  localparam int BARREL_TWO_MIN =
    (dslpc_pkg::BARREL_TWO_PCT * LINE_WINDOW + dslpc_pkg::PCT_SCALE - 1) / dslpc_pkg::PCT_SCALE;
  localparam int BARREL_ONE_MIN =
    (dslpc_pkg::BARREL_ONE_PCT * LINE_WINDOW + dslpc_pkg::PCT_SCALE - 1) / dslpc_pkg::PCT_SCALE;
  localparam int TRIPLE_MAX =
    (dslpc_pkg::TRIPLE_PCT * LINE_WINDOW) / dslpc_pkg::PCT_SCALE;

  logic [dslpc_pkg::COUNT_W-1:0] mem_q [LINE_WINDOW];
  logic [LINE_WINDOW-1:0]        vld_q;
  logic [AW-1:0]                 wptr_q;
  logic [AW-1:0]                 raddr_q;
  logic                          issue_q;
  logic                          p_vld_q;
  logic                          p_last_q;
  logic                          p_first_q;
  logic                          rvld_q;
  logic [dslpc_pkg::COUNT_W-1:0] rdata_q;

  logic [CW-1:0] n0_q, n1_q, n2_q, n3_q, chg_q;
  logic [CW-1:0] n0_d, n1_d, n2_d, n3_d, chg_d, chg_fin;
  logic [dslpc_pkg::COUNT_W-1:0] prev_q, first_q, val;
  logic done_q, round_q, barrel_q, triple_q;

  // Entries that were never written since reset read as zero.
  assign val = rvld_q ? rdata_q : '0;

  always_comb begin
    n0_d    = n0_q + CW'(val == 8'd0);
    n1_d    = n1_q + CW'(val == 8'd1);
    n2_d    = n2_q + CW'(val == 8'd2);
    n3_d    = n3_q + CW'(val == 8'd3);
    chg_d   = chg_q + CW'(!p_first_q && (val != prev_q));
    chg_fin = chg_d + CW'(val != first_q);
  end

  // Memory write and registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.sample) begin
      mem_q[wptr_q] <= data_i;
    end
    rdata_q <= mem_q[raddr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      wptr_q    <= '0;
      raddr_q   <= '0;
      issue_q   <= 1'b0;
      p_vld_q   <= 1'b0;
      p_last_q  <= 1'b0;
      p_first_q <= 1'b0;
      rvld_q    <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      if (cmd_i.sample) begin
        vld_q[wptr_q] <= 1'b1;
        wptr_q        <= (wptr_q == LAST) ? '0 : wptr_q + 1'b1;
      end
      if (cmd_i.scan) begin
        issue_q <= 1'b1;
        raddr_q <= '0;
      end else if (issue_q) begin
        if (raddr_q == LAST) begin
          issue_q <= 1'b0;
        end else begin
          raddr_q <= raddr_q + 1'b1;
        end
      end
      p_vld_q   <= issue_q;
      p_last_q  <= issue_q && (raddr_q == LAST);
      p_first_q <= issue_q && (raddr_q == '0);
      rvld_q    <= vld_q[raddr_q];
      done_q    <= p_vld_q && p_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      n0_q  <= '0;
      n1_q  <= '0;
      n2_q  <= '0;
      n3_q  <= '0;
      chg_q <= '0;
    end else if (p_vld_q) begin
      n0_q   <= n0_d;
      n1_q   <= n1_d;
      n2_q   <= n2_d;
      n3_q   <= n3_d;
      chg_q  <= chg_d;
      prev_q <= val;
      if (p_first_q) begin
        first_q <= val;
      end
      if (p_last_q) begin
        round_q  <= (n0_d >= CW'(ROUND_ZERO_MIN)) && (n1_d >= CW'(ROUND_ONE_MIN)) &&
                    (chg_fin >= CW'(dslpc_pkg::ROUND_MIN_CHANGES));
        barrel_q <= (n2_d >= CW'(BARREL_TWO_MIN)) && (n1_d >= CW'(BARREL_ONE_MIN)) &&
                    (chg_fin >= CW'(dslpc_pkg::BARREL_MIN_CHANGES));
        triple_q <= n3_d > CW'(TRIPLE_MAX);
      end
    end
  end

  assign res_o.done       = done_q;
  assign res_o.roundabout = round_q;
  assign res_o.barrel     = barrel_q;
  assign res_o.triple     = triple_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sample |-> !issue_q && !p_vld_q)
    else $error("line window written during a sweep");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(p_last_q))
    else $error("line sweep finished without its last entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_last_q |-> !issue_q)
    else $error("line sweep still reading after its last entry");

endmodule

`default_nettype wire

// ===== src/dslpc_sensor_runs.sv =====
// ----------------------------------------------------------------------------
// Sensor window run counter
// Holds the active sensor ring in a synchronous memory, counts runs of wide
// samples in array order and clears the ring when the look-ahead entry is wide.
// ----------------------------------------------------------------------------
`default_nettype none

module dslpc_sensor_runs #(
  parameter int SENSOR_WINDOW = dslpc_pkg::SENSOR_WINDOW_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire dslpc_pkg::scan_cmd_t        cmd_i,
  input  wire [dslpc_pkg::COUNT_W-1:0]     data_i,
  input  wire [dslpc_pkg::THR_W-1:0]       threshold_i,
  output dslpc_pkg::sensor_res_t           res_o
);

  localparam int AW = $clog2(SENSOR_WINDOW);
  localparam logic [AW-1:0] LAST = AW'(SENSOR_WINDOW - 1);

  logic [dslpc_pkg::COUNT_W-1:0] mem_q [SENSOR_WINDOW];
  logic [SENSOR_WINDOW-1:0]      vld_q;
  logic [AW-1:0]                 wptr_q;
  logic [AW-1:0]                 raddr_q;
  logic [AW-1:0]                 chk_idx;
  logic                          issue_q;
  logic                          p_vld_q;
  logic                          p_last_q;
  logic                          p_chk_q;
  logic                          rvld_q;
  logic [dslpc_pkg::COUNT_W-1:0] rdata_q;
  logic [dslpc_pkg::COUNT_W-1:0] val;
  logic                          wide;
  logic                          chk_wide;
  logic                          in_run_q;
  logic                          chk_q;
  logic [1:0]                    runs_q, runs_d, runs_fin;
  logic                          done_q, finish_q, crossing_q;

  // Run counts saturate at three; anything above two means neither mark.
  function automatic logic [1:0] sat_inc(input logic [1:0] cnt, input logic inc);
    logic [1:0] res;
    res = (inc && (cnt != 2'd3)) ? cnt + 2'd1 : cnt;
    return res;
  endfunction

  assign chk_idx  = (wptr_q == LAST) ? '0 : wptr_q + 1'b1;
  assign val      = rvld_q ? rdata_q : '0;
  assign wide     = val > threshold_i;
  assign chk_wide = p_chk_q ? wide : chk_q;
  assign runs_d   = sat_inc(runs_q, in_run_q && !wide);
  assign runs_fin = sat_inc(runs_q, in_run_q || wide);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sample) begin
      mem_q[wptr_q] <= data_i;
    end
    rdata_q <= mem_q[raddr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      wptr_q   <= '0;
      raddr_q  <= '0;
      issue_q  <= 1'b0;
      p_vld_q  <= 1'b0;
      p_last_q <= 1'b0;
      p_chk_q  <= 1'b0;
      rvld_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      if (cmd_i.sample) begin
        vld_q[wptr_q] <= 1'b1;
        wptr_q        <= (wptr_q == LAST) ? '0 : wptr_q + 1'b1;
      end
      if (cmd_i.scan) begin
        issue_q <= 1'b1;
        raddr_q <= '0;
      end else if (issue_q) begin
        if (raddr_q == LAST) begin
          issue_q <= 1'b0;
        end else begin
          raddr_q <= raddr_q + 1'b1;
        end
      end
      p_vld_q  <= issue_q;
      p_last_q <= issue_q && (raddr_q == LAST);
      p_chk_q  <= issue_q && (raddr_q == chk_idx);
      rvld_q   <= vld_q[raddr_q];
      done_q   <= p_vld_q && p_last_q;
      // A wide look-ahead entry empties the whole window.
      if (p_vld_q && p_last_q && chk_wide) begin
        vld_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      runs_q   <= '0;
      in_run_q <= 1'b0;
      chk_q    <= 1'b0;
    end else if (p_vld_q) begin
      runs_q   <= runs_d;
      in_run_q <= wide;
      chk_q    <= chk_wide;
      if (p_last_q) begin
        finish_q   <= chk_wide && (runs_fin == 2'd1);
        crossing_q <= chk_wide && (runs_fin == 2'd2);
      end
    end
  end

  assign res_o.done     = done_q;
  assign res_o.finish   = finish_q;
  assign res_o.crossing = crossing_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sample |-> !issue_q && !p_vld_q)
    else $error("sensor window written during a sweep");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(p_last_q))
    else $error("sensor sweep finished without its last entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && $past(chk_wide)) |-> (vld_q == '0))
    else $error("sensor window not cleared after a wide look-ahead entry");

endmodule

`default_nettype wire

// ===== src/distance_sampled_line_pattern_classifier.sv =====
// ----------------------------------------------------------------------------
// Distance sampled line pattern classifier
// Samples line and sensor counts by travelled distance into two ring windows
// and reports finish, crossing and three line patterns once per tick.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                   Payload
//  in       input      in_valid_i / in_stall_o     travel_distance, line_count,
//                                                  active_sensors
//  out      output     out_valid_o / out_stall_i   finish, crossing, roundabout,
//                                                  barrel, triple
//  cfg      input      cfg_we_i                    cfg_idx_i, cfg_data_i
//
//  A tick runs from transfer through the sample, scan, wait and output
//  states; the wait ends with the one-entry-per-cycle sweep of the larger
//  window memory. One tick is in work at a time; the next is taken
//  while the previous result still waits in the output register.
//  Reset clears both windows at once through per-entry valid bits.
//  A stalled output holds the sweep result until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_sampled_line_pattern_classifier #(
  parameter int LINE_WINDOW   = dslpc_pkg::LINE_WINDOW_DEF,
  parameter int SENSOR_WINDOW = dslpc_pkg::SENSOR_WINDOW_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire [dslpc_pkg::DIST_W-1:0]        travel_distance_i,
  input  wire [dslpc_pkg::COUNT_W-1:0]       line_count_i,
  input  wire [dslpc_pkg::COUNT_W-1:0]       active_sensors_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic                               finish_mark_o,
  output logic                               crossing_mark_o,
  output logic                               roundabout_pattern_o,
  output logic                               barrel_pattern_o,
  output logic                               triple_pattern_o,
  input  wire                                cfg_we_i,
  input  wire [dslpc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire [dslpc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  dslpc_pkg::ctrl_state_e state_q, state_d;

  logic [dslpc_pkg::STEP_W-1:0]  line_step_q, sensor_step_q;
  logic [dslpc_pkg::THR_W-1:0]   threshold_q;
  logic [dslpc_pkg::DIST_W-1:0]  dist_q, last_line_q, last_sensor_q;
  logic [dslpc_pkg::DIST_W-1:0]  line_diff, sensor_diff;
  logic [dslpc_pkg::COUNT_W-1:0] lines_q, active_q;
  logic                          line_hit, sensor_hit;
  logic                          got_line_q, got_sensor_q, both_done;
  logic                          in_xfer, load;
  logic                          out_valid_q;
  logic finish_q, crossing_q, round_q, barrel_q, triple_q;

  dslpc_pkg::scan_cmd_t   line_cmd, sensor_cmd;
  dslpc_pkg::line_res_t   line_res;
  dslpc_pkg::sensor_res_t sensor_res;

  // Differences wrap modulo 2^32, so a reading below the last sample is a
  // large forward advance.
  assign line_diff   = dist_q - last_line_q;
  assign sensor_diff = dist_q - last_sensor_q;
  assign line_hit    = line_diff > {{(dslpc_pkg::DIST_W - dslpc_pkg::STEP_W){1'b0}}, line_step_q};
  assign sensor_hit  = sensor_diff >
                       {{(dslpc_pkg::DIST_W - dslpc_pkg::STEP_W){1'b0}}, sensor_step_q};
  assign both_done   = (got_line_q || line_res.done) && (got_sensor_q || sensor_res.done);
  assign in_xfer     = in_valid_i && !in_stall_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dslpc_pkg::ST_IDLE:   if (in_valid_i) state_d = dslpc_pkg::ST_SAMPLE;
      dslpc_pkg::ST_SAMPLE: state_d = dslpc_pkg::ST_SCAN;
      dslpc_pkg::ST_SCAN:   state_d = dslpc_pkg::ST_WAIT;
      dslpc_pkg::ST_WAIT:   if (both_done) state_d = dslpc_pkg::ST_OUT;
      dslpc_pkg::ST_OUT:    if (!out_valid_q || !out_stall_i) state_d = dslpc_pkg::ST_IDLE;
      default:              state_d = dslpc_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_stall_o        = 1'b1;
    line_cmd.sample   = 1'b0;
    line_cmd.scan     = 1'b0;
    sensor_cmd.sample = 1'b0;
    sensor_cmd.scan   = 1'b0;
    load              = 1'b0;
    unique case (state_q)
      dslpc_pkg::ST_IDLE:   in_stall_o = 1'b0;
      dslpc_pkg::ST_SAMPLE: begin
        line_cmd.sample   = line_hit;
        sensor_cmd.sample = sensor_hit;
      end
      dslpc_pkg::ST_SCAN: begin
        line_cmd.scan   = 1'b1;
        sensor_cmd.scan = 1'b1;
      end
      dslpc_pkg::ST_WAIT: ;
      dslpc_pkg::ST_OUT:  load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= dslpc_pkg::ST_IDLE;
      line_step_q   <= dslpc_pkg::LINE_STEP_RST;
      sensor_step_q <= dslpc_pkg::SENSOR_STEP_RST;
      threshold_q   <= dslpc_pkg::THRESHOLD_RST;
      last_line_q   <= '0;
      last_sensor_q <= '0;
      got_line_q    <= 1'b0;
      got_sensor_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          dslpc_pkg::CFG_LINE_STEP:   line_step_q   <= cfg_data_i;
          dslpc_pkg::CFG_SENSOR_STEP: sensor_step_q <= cfg_data_i;
          dslpc_pkg::CFG_THRESHOLD:   threshold_q   <= cfg_data_i[dslpc_pkg::THR_W-1:0];
          default: ;
        endcase
      end
      if (line_cmd.sample) begin
        last_line_q <= dist_q;
      end
      if (sensor_cmd.sample) begin
        last_sensor_q <= dist_q;
      end
      if (line_cmd.scan) begin
        got_line_q   <= 1'b0;
        got_sensor_q <= 1'b0;
      end else begin
        if (line_res.done) got_line_q <= 1'b1;
        if (sensor_res.done) got_sensor_q <= 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      dist_q   <= travel_distance_i;
      lines_q  <= line_count_i;
      active_q <= active_sensors_i;
    end
    if (load) begin
      finish_q   <= sensor_res.finish;
      crossing_q <= sensor_res.crossing;
      round_q    <= line_res.roundabout;
      barrel_q   <= line_res.barrel;
      triple_q   <= line_res.triple;
    end
  end

  dslpc_line_hist #(
    .LINE_WINDOW(LINE_WINDOW)
  ) u_line (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (line_cmd),
    .data_i (lines_q),
    .res_o  (line_res)
  );

  dslpc_sensor_runs #(
    .SENSOR_WINDOW(SENSOR_WINDOW)
  ) u_sensor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (sensor_cmd),
    .data_i      (active_q),
    .threshold_i (threshold_q),
    .res_o       (sensor_res)
  );

  assign out_valid_o          = out_valid_q;
  assign finish_mark_o        = finish_q;
  assign crossing_mark_o      = crossing_q;
  assign roundabout_pattern_o = round_q;
  assign barrel_pattern_o     = barrel_q;
  assign triple_pattern_o     = triple_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(finish_mark_o && crossing_mark_o))
    else $error("finish and crossing reported together");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_res.done |-> (state_q == dslpc_pkg::ST_WAIT))
    else $error("line sweep finished outside the wait state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sensor_res.done |-> (state_q == dslpc_pkg::ST_WAIT))
    else $error("sensor sweep finished outside the wait state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q && (state_q == dslpc_pkg::ST_IDLE))
    else $error("result load did not raise the output");

endmodule

`default_nettype wire
